@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the phase current conditioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("phase current conditioner: check failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define PCC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("phase current conditioner: check failed");

`endif

@@ rtl/pcc_pkg.sv @@
// Types, constants and codes of the phase current conditioner.
package pcc_pkg;

  // Build option: 1 selects the single-shunt reconstruction path.
  localparam bit ONE_SHUNT = 1'b0;

  localparam int SampW  = 12;
  localparam int CurW   = 24;
  localparam int GainW  = 24;
  localparam int CoefW  = 16;
  localparam int AccW   = 32;
  localparam int OrdW   = 2;
  localparam int OpW    = 25;
  localparam int ProdW  = 2 * OpW;
  localparam int CfgIdxW = 3;
  localparam int CfgW   = 24;

  localparam int CalShift  = 4;
  localparam int IntShift  = 8;
  localparam int FilShift  = 16;
  localparam int NullShift = 8;

  localparam logic signed [CurW-1:0] CUR_MAX = {1'b0, {(CurW-1){1'b1}}};
  localparam logic signed [CurW-1:0] CUR_MIN = {1'b1, {(CurW-1){1'b0}}};
  localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};

  localparam logic signed [GainW-1:0] GAIN_RESET  = GainW'(65536);
  localparam logic [CoefW-1:0]        COEFF_RESET = {CoefW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_U,
    REG_GAIN_V,
    REG_GAIN_W,
    REG_OFF_U,
    REG_OFF_V,
    REG_OFF_W,
    REG_COEFF,
    REG_NULL_GAIN
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SH_CAL,
    SH_INT,
    SH_FIL
  } rnd_shift_e;

  // Control of one operation of the shared multiply unit.
  typedef struct packed {
    rnd_shift_e              shift;
    logic                    sat32;
    logic signed [AccW-1:0]  addend;
  } mac_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_CAL_WB,
    ST_NULL,
    ST_PERM,
    ST_FIL,
    ST_FIL_WB,
    ST_INT,
    ST_INT_WB,
    ST_OUT
  } seq_state_e;

endpackage

@@ rtl/pcc_if.sv @@
// Valid/ready channel interfaces for sample sets and filtered currents.
interface pcc_in_if;
  logic                              valid;
  logic                              ready;
  logic [pcc_pkg::SampW-1:0]         sample_a;
  logic [pcc_pkg::SampW-1:0]         sample_b;
  logic [pcc_pkg::SampW-1:0]         sample_c;
  logic [pcc_pkg::OrdW-1:0]          order_u;
  logic [pcc_pkg::OrdW-1:0]          order_v;
  logic [pcc_pkg::OrdW-1:0]          order_w;
  logic                              null_update;

  modport source (output valid, sample_a, sample_b, sample_c, order_u, order_v, order_w,
                  null_update, input ready);
  modport sink (input valid, sample_a, sample_b, sample_c, order_u, order_v, order_w,
                null_update, output ready);
endinterface

interface pcc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcc_pkg::CurW-1:0]   current_u;
  logic signed [pcc_pkg::CurW-1:0]   current_v;
  logic signed [pcc_pkg::CurW-1:0]   current_w;

  modport source (output valid, current_u, current_v, current_w, input ready);
  modport sink (input valid, current_u, current_v, current_w, output ready);
endinterface

@@ rtl/pcc_mac.sv @@
// Shared multiply unit: registered product, then round-shift, add and saturate.
module pcc_mac (
  input  logic                                  clk_i,
  input  logic                                  issue_i,
  input  logic signed [pcc_pkg::OpW-1:0]        a_i,
  input  logic signed [pcc_pkg::OpW-1:0]        b_i,
  input  pcc_pkg::mac_op_t                      op_i,
  output logic signed [pcc_pkg::AccW-1:0]       result_o
);

  localparam int SumW = pcc_pkg::ProdW + 1;

  logic signed [pcc_pkg::ProdW-1:0] prod_q;
  pcc_pkg::mac_op_t                 op_q;

  logic signed [SumW-1:0] prod_ext;
  logic signed [SumW-1:0] rnd;
  logic signed [SumW-1:0] shifted;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] hi;
  logic signed [SumW-1:0] lo;
  logic signed [SumW-1:0] clamped;

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= a_i * b_i;
      op_q   <= op_i;
    end
  end

  always_comb begin
    prod_ext = SumW'(prod_q);
    rnd      = prod_ext;
    shifted  = prod_ext;
    case (op_q.shift)
      pcc_pkg::SH_CAL: begin
        rnd     = prod_ext + SumW'(1 << (pcc_pkg::CalShift - 1));
        shifted = rnd >>> pcc_pkg::CalShift;
      end
      pcc_pkg::SH_INT: begin
        rnd     = prod_ext + SumW'(1 << (pcc_pkg::IntShift - 1));
        shifted = rnd >>> pcc_pkg::IntShift;
      end
      pcc_pkg::SH_FIL: begin
        rnd     = prod_ext + SumW'(1 << (pcc_pkg::FilShift - 1));
        shifted = rnd >>> pcc_pkg::FilShift;
      end
      default: begin
        rnd     = prod_ext;
        shifted = prod_ext;
      end
    endcase
    sum = shifted + SumW'(op_q.addend);
    hi  = op_q.sat32 ? SumW'(pcc_pkg::ACC_MAX) : SumW'(pcc_pkg::CUR_MAX);
    lo  = op_q.sat32 ? SumW'(pcc_pkg::ACC_MIN) : SumW'(pcc_pkg::CUR_MIN);
    if (sum > hi) begin
      clamped = hi;
    end else if (sum < lo) begin
      clamped = lo;
    end else begin
      clamped = sum;
    end
    result_o = clamped[pcc_pkg::AccW-1:0];
  end

endmodule

@@ rtl/phase_current_conditioner.sv @@
// Top level of the phase current conditioner: sequencer, state and register file.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        sample_a/b/c, order_u/v/w, null_update
//   out_o     out  valid/ready        current_u/v/w
//   cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_data_i
//
// Every product goes through the one shared multiply unit. Input is ready only while the
// sequencer is idle, so a new transaction is taken only after the last one has left it.
// Reset clears the sequencer, the filter and null state and loads register defaults.
// A stalled result holds in the output register while the next transaction is taken;
// the sequencer waits in its final step only if that register is still full.
module phase_current_conditioner #(
  parameter bit OneShunt = pcc_pkg::ONE_SHUNT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pcc_in_if.sink                            in_i,
  pcc_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [pcc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pcc_pkg::CfgW-1:0]          cfg_data_i
);

  localparam int CurW = pcc_pkg::CurW;
  localparam int AccW = pcc_pkg::AccW;
  localparam int OpW  = pcc_pkg::OpW;

  // Last sample index of the calibration pass and of the integrator pass.
  localparam logic [1:0] LastCal = OneShunt ? 2'd1 : 2'd2;
  localparam logic [1:0] LastInt = OneShunt ? 2'd0 : 2'd2;
  localparam logic [1:0] LastPh  = 2'd2;
  localparam logic [1:0] PhV     = 2'd1;

  function automatic logic signed [CurW-1:0] sat24(input logic signed [CurW+1:0] v);
    logic signed [CurW+1:0] hi;
    logic signed [CurW+1:0] lo;
    hi = (CurW+2)'(pcc_pkg::CUR_MAX);
    lo = (CurW+2)'(pcc_pkg::CUR_MIN);
    if (v > hi) begin
      return pcc_pkg::CUR_MAX;
    end else if (v < lo) begin
      return pcc_pkg::CUR_MIN;
    end
    return v[CurW-1:0];
  endfunction

  // Configuration registers
  logic signed [pcc_pkg::GainW-1:0] gain_q [3];
  logic signed [CurW-1:0]           off_q [3];
  logic [pcc_pkg::CoefW-1:0]        coeff_q;
  logic [pcc_pkg::CoefW-1:0]        ngain_q;

  // Persistent filter and null-integrator state
  logic signed [CurW-1:0] filt_q [3];
  logic signed [AccW-1:0] acc_q [3];

  // Captured transaction and working values
  logic [pcc_pkg::SampW-1:0] samp_q [3];
  logic [pcc_pkg::OrdW-1:0]  ord_q [3];
  logic                      upd_q;
  logic signed [CurW-1:0]    corr_q [3];
  logic signed [CurW-1:0]    ph_q [3];
  logic signed [OpW-1:0]     nv_q;

  // Output register
  logic signed [CurW-1:0] out_q [3];
  logic                   out_valid_q;

  pcc_pkg::seq_state_e state_q, state_d;
  logic [1:0]          idx_q, idx_d;

  logic                   in_acc;
  logic                   out_load;
  logic [1:0]             ch;
  logic signed [AccW:0]   nv_rnd;
  logic signed [CurW+1:0] ndiff;
  logic signed [CurW:0]   csum;
  logic signed [CurW-1:0] err;
  logic signed [CurW-1:0] xv [4];

  logic                     mac_issue;
  logic signed [OpW-1:0]    mac_a;
  logic signed [OpW-1:0]    mac_b;
  pcc_pkg::mac_op_t         mac_op;
  logic signed [AccW-1:0]   mac_res;

  assign in_i.ready = (state_q == pcc_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == pcc_pkg::ST_OUT) && (!out_valid_q || out_o.ready);

  // Single shunt always works on the v-phase calibration and integrator.
  assign ch = OneShunt ? PhV : idx_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        gain_q[i] <= pcc_pkg::GAIN_RESET;
        off_q[i]  <= '0;
      end
      coeff_q <= pcc_pkg::COEFF_RESET;
      ngain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pcc_pkg::cfg_reg_e'(cfg_idx_i))
        pcc_pkg::REG_GAIN_U:    gain_q[0] <= cfg_data_i;
        pcc_pkg::REG_GAIN_V:    gain_q[1] <= cfg_data_i;
        pcc_pkg::REG_GAIN_W:    gain_q[2] <= cfg_data_i;
        pcc_pkg::REG_OFF_U:     off_q[0]  <= cfg_data_i;
        pcc_pkg::REG_OFF_V:     off_q[1]  <= cfg_data_i;
        pcc_pkg::REG_OFF_W:     off_q[2]  <= cfg_data_i;
        pcc_pkg::REG_COEFF:     coeff_q   <= cfg_data_i[pcc_pkg::CoefW-1:0];
        pcc_pkg::REG_NULL_GAIN: ngain_q   <= cfg_data_i[pcc_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcc_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state: calibrate and null each sample, rebuild phases, filter each
  // phase, then optionally integrate the nulls, then hand over the result.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    mac_issue = 1'b0;
    unique case (state_q)
      pcc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = pcc_pkg::ST_CAL;
          idx_d   = '0;
        end
      end
      pcc_pkg::ST_CAL: begin
        mac_issue = 1'b1;
        state_d   = pcc_pkg::ST_CAL_WB;
      end
      pcc_pkg::ST_CAL_WB: state_d = pcc_pkg::ST_NULL;
      pcc_pkg::ST_NULL: begin
        if (idx_q == LastCal) begin
          state_d = pcc_pkg::ST_PERM;
          idx_d   = '0;
        end else begin
          state_d = pcc_pkg::ST_CAL;
          idx_d   = idx_q + 2'd1;
        end
      end
      pcc_pkg::ST_PERM: state_d = pcc_pkg::ST_FIL;
      pcc_pkg::ST_FIL: begin
        mac_issue = 1'b1;
        state_d   = pcc_pkg::ST_FIL_WB;
      end
      pcc_pkg::ST_FIL_WB: begin
        if (idx_q == LastPh) begin
          idx_d   = '0;
          state_d = upd_q ? pcc_pkg::ST_INT : pcc_pkg::ST_OUT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = pcc_pkg::ST_FIL;
        end
      end
      pcc_pkg::ST_INT: begin
        mac_issue = 1'b1;
        state_d   = pcc_pkg::ST_INT_WB;
      end
      pcc_pkg::ST_INT_WB: begin
        if (idx_q == LastInt) begin
          idx_d   = '0;
          state_d = pcc_pkg::ST_OUT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = pcc_pkg::ST_INT;
        end
      end
      pcc_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = pcc_pkg::ST_IDLE;
        end
      end
      default: state_d = pcc_pkg::ST_IDLE;
    endcase
  end

  // Null value in Q12.12 and the corrected sample
  assign nv_rnd = (AccW+1)'(acc_q[ch]) + (AccW+1)'(1 << (pcc_pkg::NullShift - 1));
  assign ndiff  = (CurW+2)'(corr_q[idx_q]) - (CurW+2)'(nv_q);

  // Single-shunt rebuilt values: -b, b-a, a, and zero for the unused code
  assign xv[0] = sat24(-(CurW+2)'(corr_q[1]));
  assign xv[1] = sat24((CurW+2)'(corr_q[1]) - (CurW+2)'(corr_q[0]));
  assign xv[2] = corr_q[0];
  assign xv[3] = '0;

  // Integrator input: the corrected phase, or the mean of both shunt samples
  assign csum = (CurW+1)'(corr_q[0]) + (CurW+1)'(corr_q[1]);
  assign err  = OneShunt ? CurW'(csum >>> 1) : corr_q[idx_q];

  // Operands of the shared unit
  always_comb begin
    mac_a         = OpW'($signed({1'b0, samp_q[idx_q]}));
    mac_b         = OpW'(gain_q[ch]);
    mac_op.shift  = pcc_pkg::SH_CAL;
    mac_op.sat32  = 1'b0;
    mac_op.addend = AccW'(off_q[ch]);
    case (state_q)
      pcc_pkg::ST_FIL: begin
        mac_a         = OpW'(ph_q[idx_q]) - OpW'(filt_q[idx_q]);
        mac_b         = OpW'($signed({1'b0, coeff_q}));
        mac_op.shift  = pcc_pkg::SH_FIL;
        mac_op.addend = AccW'(filt_q[idx_q]);
      end
      pcc_pkg::ST_INT: begin
        mac_a         = OpW'(err);
        mac_b         = OpW'($signed({1'b0, ngain_q}));
        mac_op.shift  = pcc_pkg::SH_INT;
        mac_op.sat32  = 1'b1;
        mac_op.addend = acc_q[ch];
      end
      default: ;
    endcase
  end

  pcc_mac u_mac (
    .clk_i    (clk_i),
    .issue_i  (mac_issue),
    .a_i      (mac_a),
    .b_i      (mac_b),
    .op_i     (mac_op),
    .result_o (mac_res)
  );

  // Capture the transaction and hold working values
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q[0] <= in_i.sample_a;
      samp_q[1] <= in_i.sample_b;
      samp_q[2] <= in_i.sample_c;
      ord_q[0]  <= in_i.order_u;
      ord_q[1]  <= in_i.order_v;
      ord_q[2]  <= in_i.order_w;
      upd_q     <= in_i.null_update;
    end
    case (state_q)
      pcc_pkg::ST_CAL:    nv_q <= OpW'(nv_rnd >>> pcc_pkg::NullShift);
      pcc_pkg::ST_CAL_WB: corr_q[idx_q] <= mac_res[CurW-1:0];
      pcc_pkg::ST_NULL:   corr_q[idx_q] <= sat24(ndiff);
      pcc_pkg::ST_PERM: begin
        for (int i = 0; i < 3; i++) begin
          ph_q[i] <= OneShunt ? xv[ord_q[i]] : corr_q[i];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i] <= filt_q[i];
      end
    end
  end

  // Filter and integrator state: advance only at write-back steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        filt_q[i] <= '0;
        acc_q[i]  <= '0;
      end
    end else begin
      if (state_q == pcc_pkg::ST_FIL_WB) begin
        filt_q[idx_q] <= mac_res[CurW-1:0];
      end
      if (state_q == pcc_pkg::ST_INT_WB) begin
        acc_q[ch] <= mac_res;
      end
    end
  end

  // Output register valid: set on load, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.current_u = out_q[0];
  assign out_o.current_v = out_q[1];
  assign out_o.current_w = out_q[2];

endmodule

@@ rtl/pcc_checker.sv @@
// Port-level checks of the phase current conditioner, bound to its top level.
`include "assert_macros.svh"

module pcc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [pcc_pkg::CurW-1:0]   current_u_i,
  input logic signed [pcc_pkg::CurW-1:0]   current_v_i,
  input logic signed [pcc_pkg::CurW-1:0]   current_w_i
);

  logic [3*pcc_pkg::CurW-1:0] result_bits;

  assign result_bits = {current_u_i, current_v_i, current_w_i};

  `PCC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `PCC_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(result_bits))
  `PCC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)
  `PCC_ASSERT_NOW(a_result_from_busy, $rose(out_valid_i), $past(!in_ready_i))

endmodule

bind phase_current_conditioner pcc_checker u_pcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .current_u_i (out_o.current_u),
  .current_v_i (out_o.current_v),
  .current_w_i (out_o.current_w)
);
